/* src/sspg_pkg.sv */
// Package for the stepper step pulse generator.
// Holds the request codes, direction codes, register indexes and reset values.
// No dependencies.
package sspg_pkg;

	// Request codes carried by req_type.
	typedef enum logic [2:0] {
		REQ_TICK      = 3'd0,
		REQ_SET_SPEED = 3'd1,
		REQ_ENABLE    = 3'd2,
		REQ_STOP      = 3'd3,
		REQ_RESET_POS = 3'd4
	} req_t;

	// Last direction seen by the tick logic.
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_TICK_RATE     = 3'd0,
		CFG_MAX_STEP_RATE = 3'd1,
		CFG_SOFT_LIMIT    = 3'd2,
		CFG_INVERT_DIR    = 3'd3,
		CFG_POS_DIR_HIGH  = 3'd4,
		CFG_EN_ACTIVE_LOW = 3'd5
	} cfg_reg_t;

	localparam int CFG_IDX_W    = 3;
	localparam int SOFT_LIMIT_W = 23;

	// Reset values of the configuration registers.
	localparam int unsigned TICK_RATE_RST     = 20000;
	localparam int unsigned MAX_STEP_RATE_RST = 10000;
	localparam int unsigned SOFT_LIMIT_RST    = 100000;

endpackage

/* src/stepper_step_pulse_generator.sv */
// Stepper step pulse generator, top level and only module.
// Depends on sspg_pkg for request, direction and register codes.
//
// The block takes one request beat per cycle while not stalled (tick, set
// speed, enable, stop, reset position) and returns one result beat per request
// showing the pin levels, position, limit flag and speed after it. A request is
// captured in an input register; once the result register is free, a single
// phase add, threshold compare and soft limit compare update the state and load
// the result register. A new request is accepted every cycle unless stalled. The
// rate is set by that single state update, which each request needs before the
// next one can run. The input side stalls only while the result register is
// full and stalled. Configuration writes take effect at once and belong to
// idle periods; enable_pin polarity is applied when a result is formed.
module stepper_step_pulse_generator
	import sspg_pkg::*;
#(
	parameter int POSITION_WIDTH = 24,
	parameter int RATE_WIDTH     = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_idx,
	input  logic [((RATE_WIDTH > SOFT_LIMIT_W) ? RATE_WIDTH : SOFT_LIMIT_W)-1:0] cfg_data,
	// Request channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    req_type,
	input  logic signed [RATE_WIDTH:0]    speed_value,
	input  logic                          enable_value,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          step_pin,
	output logic                          dir_pin,
	output logic                          enable_pin,
	output logic signed [POSITION_WIDTH-1:0] position_now,
	output logic                          limit_hit,
	output logic signed [RATE_WIDTH:0]    speed_now
);

	localparam int R  = RATE_WIDTH;
	localparam int P  = POSITION_WIDTH;
	localparam int PH = R + 1;
	localparam int LW = ((P > SOFT_LIMIT_W) ? P : SOFT_LIMIT_W) + 2;
	localparam logic [LW-1:0] POS_MAX = {{(LW-P+1){1'b0}}, {(P-1){1'b1}}};

	// Configuration registers.
	logic [R-1:0]            tick_q;
	logic [R-1:0]            max_q;
	logic [SOFT_LIMIT_W-1:0] soft_q;
	logic                    inv_q;
	logic                    pdh_q;
	logic                    eal_q;

	// Block state.
	logic signed [R:0]   speed_q;
	logic [PH-1:0]       phase_q;
	logic [P-1:0]        pos_q;
	dir_t                last_dir_q;
	logic                en_q;
	logic                limit_q;
	logic                step_q;
	logic                dir_lvl_q;

	// Input register stage.
	logic                s1_valid_q;
	req_t                req_s1;
	logic signed [R:0]   speed_s1;
	logic                enable_s1;

	// Result register.
	logic                out_valid_q;
	logic                step_out_q;
	logic                dir_out_q;
	logic                en_out_q;
	logic [P-1:0]        pos_out_q;
	logic                limit_out_q;
	logic signed [R:0]   speed_out_q;

	// Handshake.
	logic out_free;
	logic adv;
	logic accept;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign accept   = in_valid && !in_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= R'(TICK_RATE_RST);
			max_q  <= R'(MAX_STEP_RATE_RST);
			soft_q <= SOFT_LIMIT_W'(SOFT_LIMIT_RST);
			inv_q  <= 1'b0;
			pdh_q  <= 1'b1;
			eal_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				CFG_TICK_RATE:     tick_q <= cfg_data[R-1:0];
				CFG_MAX_STEP_RATE: max_q  <= cfg_data[R-1:0];
				CFG_SOFT_LIMIT:    soft_q <= cfg_data[SOFT_LIMIT_W-1:0];
				CFG_INVERT_DIR:    inv_q  <= cfg_data[0];
				CFG_POS_DIR_HIGH:  pdh_q  <= cfg_data[0];
				CFG_EN_ACTIVE_LOW: eal_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Capture of an accepted request beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= req_t'(req_type);
			speed_s1  <= speed_value;
			enable_s1 <= enable_value;
		end
	end

	// Tick datapath: direction, clamped magnitude and phase step.
	logic                spd_nz;
	logic                spd_pos;
	dir_t                dir_new;
	logic signed [R:0]   spd_neg;
	logic [R-1:0]        mag_raw;
	logic [R-1:0]        mag_cl;
	logic [R+1:0]        ph_sum;
	logic [R+1:0]        ph_sub;
	logic                ph_wrap;
	logic                dir_d;
	logic                dir_pin_new;

	assign spd_nz      = speed_q != '0;
	assign spd_pos     = !speed_q[R];
	assign dir_new     = spd_pos ? DIR_POS : DIR_NEG;
	assign spd_neg     = -speed_q;
	assign mag_raw     = spd_pos ? speed_q[R-1:0] : spd_neg[R-1:0];
	assign mag_cl      = (mag_raw > tick_q) ? tick_q : mag_raw;
	assign ph_sum      = {1'b0, phase_q} + {2'b00, mag_cl};
	assign ph_sub      = ph_sum - {2'b00, tick_q};
	assign ph_wrap     = ph_sum >= {2'b00, tick_q};
	assign dir_d       = inv_q ? !spd_pos : spd_pos;
	assign dir_pin_new = pdh_q ? dir_d : !dir_d;

	// Soft limit check on the position the step would reach.
	logic signed [LW-1:0] pos_ext;
	logic signed [LW-1:0] pos_next;
	logic [LW-1:0]        soft_ext;
	logic signed [LW-1:0] lim;
	logic                 refuse;

	assign pos_ext  = {{(LW-P){pos_q[P-1]}}, pos_q};
	assign pos_next = spd_pos ? pos_ext + LW'(1) : pos_ext - LW'(1);
	assign soft_ext = {{(LW-SOFT_LIMIT_W){1'b0}}, soft_q};
	assign lim      = (soft_ext < POS_MAX) ? soft_ext : POS_MAX;
	assign refuse   = (pos_next > lim) || (pos_next < -lim);

	// Set speed clamp to the smaller of the maximum rate and the tick rate.
	logic [R-1:0]      clim;
	logic signed [R:0] clim_s;
	logic signed [R:0] spd_clamped;

	assign clim        = (max_q < tick_q) ? max_q : tick_q;
	assign clim_s      = {1'b0, clim};
	assign spd_clamped = (speed_s1 > clim_s) ? clim_s :
	                     (speed_s1 < -clim_s) ? -clim_s : speed_s1;

	// Next state for the request in the input register.
	logic signed [R:0] speed_d;
	logic [PH-1:0]     phase_d;
	logic [P-1:0]      pos_d;
	dir_t              last_dir_d;
	logic              en_d;
	logic              limit_d;
	logic              step_d;
	logic              dir_lvl_d;
	logic              dir_change;
	logic              stepped;

	always_comb begin
		speed_d    = speed_q;
		phase_d    = phase_q;
		pos_d      = pos_q;
		last_dir_d = last_dir_q;
		en_d       = en_q;
		limit_d    = limit_q;
		step_d     = step_q;
		dir_lvl_d  = dir_lvl_q;
		dir_change = 1'b0;
		stepped    = 1'b0;
		case (req_s1)
			REQ_TICK: begin
				step_d = 1'b0;
				if (en_q && spd_nz) begin
					if (dir_new != last_dir_q) begin
						dir_change = 1'b1;
						dir_lvl_d  = dir_pin_new;
						last_dir_d = dir_new;
						phase_d    = '0;
					end else if (!ph_wrap) begin
						phase_d = ph_sum[PH-1:0];
					end else begin
						phase_d = ph_sub[PH-1:0];
						if (refuse) begin
							limit_d = 1'b1;
							speed_d = '0;
						end else begin
							limit_d = 1'b0;
							pos_d   = pos_next[P-1:0];
							step_d  = 1'b1;
							stepped = 1'b1;
						end
					end
				end
			end
			REQ_SET_SPEED: begin
				speed_d = spd_clamped;
			end
			REQ_ENABLE: begin
				en_d = enable_s1;
				if (!enable_s1) begin
					speed_d = '0;
					phase_d = '0;
					step_d  = 1'b0;
				end
			end
			REQ_STOP: begin
				speed_d = '0;
				phase_d = '0;
			end
			REQ_RESET_POS: begin
				pos_d   = '0;
				limit_d = 1'b0;
			end
			default: ;
		endcase
	end

	// State update when the request moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= '0;
			phase_q    <= '0;
			pos_q      <= '0;
			last_dir_q <= DIR_NONE;
			en_q       <= 1'b0;
			limit_q    <= 1'b0;
			step_q     <= 1'b0;
			dir_lvl_q  <= 1'b0;
		end else if (adv) begin
			speed_q    <= speed_d;
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			last_dir_q <= last_dir_d;
			en_q       <= en_d;
			limit_q    <= limit_d;
			step_q     <= step_d;
			dir_lvl_q  <= dir_lvl_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_out_q  <= step_d;
			dir_out_q   <= dir_lvl_d;
			en_out_q    <= eal_q ? !en_d : en_d;
			pos_out_q   <= pos_d;
			limit_out_q <= limit_d;
			speed_out_q <= speed_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign step_pin     = step_out_q;
	assign dir_pin      = dir_out_q;
	assign enable_pin   = en_out_q;
	assign position_now = pos_out_q;
	assign limit_hit    = limit_out_q;
	assign speed_now    = speed_out_q;

	// The input side only stalls while a request waits in the input register.
	a_stall_needs_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("input stalled with an empty input register");

	// A step moves the position by exactly one.
	a_step_moves_one : assert property (@(posedge clk) disable iff (!arst_n)
		adv && stepped |=>
		(pos_q == $past(pos_q) + P'(1)) || (pos_q == $past(pos_q) - P'(1)))
		else $error("step did not move the position by one");

	// A change of direction clears the phase.
	a_dir_change_phase : assert property (@(posedge clk) disable iff (!arst_n)
		adv && dir_change |=> phase_q == '0)
		else $error("phase not cleared on a change of direction");

	// A refused step leaves the speed at zero and the limit flag set.
	a_refuse_stops : assert property (@(posedge clk) disable iff (!arst_n)
		adv && (req_s1 == REQ_TICK) && en_q && spd_nz && !dir_change && ph_wrap && refuse
		|=> (speed_q == '0) && limit_q)
		else $error("refused step did not stop the motor");

endmodule
